FILE: hw/rtl/lcsr_pkg.sv
// lcsr_pkg: shared types and constants for the load cell serial reader
// no dependencies; used by every module of the block except lcsr_fifo

package lcsr_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // fixed field widths
  localparam int COUNT_W = 9;
  localparam int GAIN_W  = 2;
  localparam int RAW_W   = 24;
  localparam int NET_W   = 25;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PULSES  = 2'd0,
    REG_SAMPLE_COUNT = 2'd1,
    REG_TARE_OFFSET  = 2'd2,
    REG_POWER_DOWN   = 2'd3
  } lcsr_reg_t;

  // one classified tick, front to back
  typedef struct packed {
    logic               sck;
    logic               raw_valid;
    logic [RAW_W-1:0]   raw_sample;
    logic               avg_req;
    logic [COUNT_W-1:0] avg_count;
    logic [RAW_W-1:0]   tare;
  } lcsr_tick_t;

endpackage

FILE: hw/rtl/lcsr_fifo.sv
// lcsr_fifo: short register queue between the tick front end and the back end
// no package dependency; width and depth come from the instantiating module

module lcsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [LVL_W-1:0] level_r;

  assign full     = (level_r == LVL_W'(DEPTH));
  assign empty    = (level_r == '0);
  assign pop_data = data_r[rd_ptr_r];

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/lcsr_front.sv
// lcsr_front: configuration registers and the per-tick serial clock sequencer
// depends on lcsr_pkg; classifies each tick and pushes it into the queue

module lcsr_front #(
  parameter int DATA_BITS   = 24,
  parameter int MAX_SAMPLES = 256,
  parameter int SUM_W       = 33
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lcsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           take,
  input  logic                           dout,
  output lcsr_pkg::lcsr_tick_t           tick,
  output logic [SUM_W-1:0]               tick_sum
);

  localparam int PIDX_W = $clog2(DATA_BITS + 4);
  localparam int WIDE_W = DATA_BITS + lcsr_pkg::RAW_W;
  localparam int CNT_W  = lcsr_pkg::COUNT_W;

  // configuration
  logic [lcsr_pkg::GAIN_W-1:0] gain_r;
  logic [CNT_W-1:0]            count_r;
  logic [lcsr_pkg::RAW_W-1:0]  tare_r;
  logic                        pdown_r;

  // frame state
  logic                 busy_r, busy_nxt;
  logic                 clk_hi_r, clk_hi_nxt;
  logic [PIDX_W-1:0]    pidx_r, pidx_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CNT_W-1:0]     tally_r, tally_nxt;

  logic [lcsr_pkg::GAIN_W-1:0] extra;
  logic [CNT_W-1:0]            eff_count;
  logic [PIDX_W-1:0]           pidx_inc;
  logic [DATA_BITS-1:0]        shift_step;
  logic signed [WIDE_W-1:0]    raw_wide;
  logic [SUM_W-1:0]            sum_add;
  logic [CNT_W-1:0]            tally_inc;
  logic                        frame_done;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= lcsr_pkg::GAIN_W'(1);
      count_r <= CNT_W'(1);
      tare_r  <= '0;
      pdown_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (lcsr_pkg::lcsr_reg_t'(cfg_index))
        lcsr_pkg::REG_GAIN_PULSES:  gain_r  <= cfg_wdata[lcsr_pkg::GAIN_W-1:0];
        lcsr_pkg::REG_SAMPLE_COUNT: count_r <= cfg_wdata[CNT_W-1:0];
        lcsr_pkg::REG_TARE_OFFSET:  tare_r  <= cfg_wdata[lcsr_pkg::RAW_W-1:0];
        lcsr_pkg::REG_POWER_DOWN:   pdown_r <= cfg_wdata[0];
      endcase
    end
  end

  // zero gain pulses act as one, count clamped to 1..MAX_SAMPLES
  always_comb begin
    extra = (gain_r == '0) ? lcsr_pkg::GAIN_W'(1) : gain_r;
    eff_count = count_r;
    if (count_r == '0) begin
      eff_count = CNT_W'(1);
    end
    if (32'(count_r) > 32'(MAX_SAMPLES)) begin
      eff_count = CNT_W'(MAX_SAMPLES);
    end
  end

  // data path of the high tick
  always_comb begin
    pidx_inc   = pidx_r + 1'b1;
    shift_step = (pidx_r < PIDX_W'(DATA_BITS)) ? {shift_r[DATA_BITS-2:0], dout} : shift_r;
    raw_wide   = WIDE_W'($signed(shift_step));
    sum_add    = sum_r + SUM_W'($signed(shift_step));
    tally_inc  = tally_r + 1'b1;
    frame_done = (pidx_inc >= PIDX_W'(DATA_BITS) + PIDX_W'(extra));
  end

  // tick sequencer
  always_comb begin
    busy_nxt   = busy_r;
    clk_hi_nxt = clk_hi_r;
    pidx_nxt   = pidx_r;
    shift_nxt  = shift_r;
    sum_nxt    = sum_r;
    tally_nxt  = tally_r;
    tick            = '0;
    tick.avg_count  = eff_count;
    tick.tare       = tare_r;
    tick_sum        = sum_add;
    if (pdown_r) begin
      busy_nxt   = 1'b0;
      pidx_nxt   = '0;
      shift_nxt  = '0;
      clk_hi_nxt = 1'b1;
      tick.sck   = 1'b1;
    end else if (!busy_r) begin
      if (!clk_hi_r && !dout) begin
        busy_nxt   = 1'b1;
        pidx_nxt   = '0;
        shift_nxt  = '0;
        clk_hi_nxt = 1'b1;
        tick.sck   = 1'b1;
      end else begin
        clk_hi_nxt = 1'b0;
        tick.sck   = 1'b0;
      end
    end else if (!clk_hi_r) begin
      clk_hi_nxt = 1'b1;
      tick.sck   = 1'b1;
    end else begin
      shift_nxt  = shift_step;
      pidx_nxt   = pidx_inc;
      clk_hi_nxt = 1'b0;
      tick.sck   = 1'b0;
      if (frame_done) begin
        busy_nxt        = 1'b0;
        pidx_nxt        = '0;
        shift_nxt       = '0;
        tick.raw_valid  = 1'b1;
        tick.raw_sample = raw_wide[lcsr_pkg::RAW_W-1:0];
        sum_nxt         = sum_add;
        tally_nxt       = tally_inc;
        if (tally_inc >= eff_count) begin
          tick.avg_req = 1'b1;
          sum_nxt      = '0;
          tally_nxt    = '0;
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      clk_hi_r <= 1'b0;
      pidx_r   <= '0;
      shift_r  <= '0;
      sum_r    <= '0;
      tally_r  <= '0;
    end else if (take) begin
      busy_r   <= busy_nxt;
      clk_hi_r <= clk_hi_nxt;
      pidx_r   <= pidx_nxt;
      shift_r  <= shift_nxt;
      sum_r    <= sum_nxt;
      tally_r  <= tally_nxt;
    end
  end

endmodule

FILE: hw/rtl/lcsr_back.sv
// lcsr_back: result stage with a bit-serial signed divider for the average
// depends on lcsr_pkg; pops classified ticks from the queue in order

module lcsr_back #(
  parameter int SUM_W = 33
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  lcsr_pkg::lcsr_tick_t               q_tick,
  input  logic [SUM_W-1:0]                   q_sum,
  output logic                               q_pop,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic                               out_sck,
  output logic                               out_raw_valid,
  output logic signed [lcsr_pkg::RAW_W-1:0]  out_raw_sample,
  output logic                               out_average_valid,
  output logic signed [lcsr_pkg::RAW_W-1:0]  out_average,
  output logic signed [lcsr_pkg::NET_W-1:0]  out_net_value
);

  localparam int CNT_W  = lcsr_pkg::COUNT_W;
  localparam int REM_W  = CNT_W + 1;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam int WIDE_W = SUM_W + lcsr_pkg::NET_W;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} state_t;

  state_t               state_r;
  lcsr_pkg::lcsr_tick_t tick_r;
  logic [SUM_W-1:0]     dvd_r;
  logic [REM_W-1:0]     rem_r;
  logic [DCNT_W-1:0]    dcnt_r;
  logic                 neg_r;

  logic                 out_valid_r;
  logic                 out_sck_r;
  logic                 out_raw_valid_r;
  logic [lcsr_pkg::RAW_W-1:0] out_raw_sample_r;
  logic                 out_average_valid_r;
  logic [lcsr_pkg::RAW_W-1:0] out_average_r;
  logic [lcsr_pkg::NET_W-1:0] out_net_value_r;

  logic                     slot_free;
  logic                     out_load;
  logic [SUM_W-1:0]         sum_mag;
  logic [REM_W-1:0]         rem_shift;
  logic                     rem_ge;
  logic [SUM_W-1:0]         quo_signed;
  logic signed [WIDE_W-1:0] quo_wide;
  logic signed [WIDE_W-1:0] tare_wide;
  logic signed [WIDE_W-1:0] net_wide;

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty && slot_free;

  // magnitude of the sum and one restoring divide step
  always_comb begin
    sum_mag    = q_sum[SUM_W-1] ? SUM_W'(0) - q_sum : q_sum;
    rem_shift  = {rem_r[CNT_W-1:0], dvd_r[SUM_W-1]};
    rem_ge     = (rem_shift >= {1'b0, tick_r.avg_count});
    quo_signed = neg_r ? SUM_W'(0) - dvd_r : dvd_r;
    quo_wide   = WIDE_W'($signed(quo_signed));
    tare_wide  = WIDE_W'($signed(tick_r.tare));
    net_wide   = quo_wide - tare_wide;
    // output register loads on a plain tick or a finished divide
    out_load   = (q_pop && !q_tick.avg_req) || ((state_r == ST_FIN) && slot_free);
  end

  // sequencer, divider and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (slot_free) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            tick_r <= q_tick;
            if (q_tick.avg_req) begin
              dvd_r   <= sum_mag;
              rem_r   <= '0;
              dcnt_r  <= '0;
              neg_r   <= q_sum[SUM_W-1];
              state_r <= ST_DIV;
            end else begin
              out_sck_r           <= q_tick.sck;
              out_raw_valid_r     <= q_tick.raw_valid;
              out_raw_sample_r    <= q_tick.raw_sample;
              out_average_valid_r <= 1'b0;
              out_average_r       <= '0;
              out_net_value_r     <= '0;
            end
          end
        end
        ST_DIV: begin
          dvd_r  <= {dvd_r[SUM_W-2:0], rem_ge};
          rem_r  <= rem_ge ? rem_shift - {1'b0, tick_r.avg_count} : rem_shift;
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCNT_W'(SUM_W - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_sck_r           <= tick_r.sck;
            out_raw_valid_r     <= tick_r.raw_valid;
            out_raw_sample_r    <= tick_r.raw_sample;
            out_average_valid_r <= 1'b1;
            out_average_r       <= quo_wide[lcsr_pkg::RAW_W-1:0];
            out_net_value_r     <= net_wide[lcsr_pkg::NET_W-1:0];
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sck           = out_sck_r;
  assign out_raw_valid     = out_raw_valid_r;
  assign out_raw_sample    = out_raw_sample_r;
  assign out_average_valid = out_average_valid_r;
  assign out_average       = out_average_r;
  assign out_net_value     = out_net_value_r;

endmodule

FILE: hw/rtl/load_cell_adc_serial_reader.sv
// load_cell_adc_serial_reader: serial clock master and averager for a bridge converter
// an ordinary tick is accepted into the queue, then popped into the output register
// throughput: one tick per cycle while neither a full queue nor out_stall holds it; a tick
//   that closes an averaged reading holds the result stage in the bit-serial divider,
//   while the front keeps taking ticks until the 4-entry queue fills
// reset: synchronous rst_n; registers return to gain 1, count 1, tare 0, powered up

module load_cell_adc_serial_reader #(
  parameter int DATA_BITS   = 24,
  parameter int MAX_SAMPLES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lcsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcsr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_dout,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_sck,
  output logic                                out_raw_valid,
  output logic signed [lcsr_pkg::RAW_W-1:0]   out_raw_sample,
  output logic                                out_average_valid,
  output logic signed [lcsr_pkg::RAW_W-1:0]   out_average,
  output logic signed [lcsr_pkg::NET_W-1:0]   out_net_value
);

  localparam int SUM_W  = DATA_BITS + lcsr_pkg::COUNT_W;
  localparam int TICK_W = $bits(lcsr_pkg::lcsr_tick_t);
  localparam int Q_W    = SUM_W + TICK_W;

  logic                 take;
  lcsr_pkg::lcsr_tick_t f_tick;
  logic [SUM_W-1:0]     f_sum;
  logic [Q_W-1:0]       q_out;
  logic                 q_full, q_empty, q_pop;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  // front: registers and tick sequencer
  lcsr_front #(
    .DATA_BITS  (DATA_BITS),
    .MAX_SAMPLES(MAX_SAMPLES),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .take     (take),
    .dout     (in_dout),
    .tick     (f_tick),
    .tick_sum (f_sum)
  );

  // queue between front and back
  lcsr_fifo #(
    .WIDTH(Q_W),
    .DEPTH(lcsr_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take),
    .push_data({f_sum, f_tick}),
    .pop      (q_pop),
    .pop_data (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: divider and output register
  lcsr_back #(
    .SUM_W(SUM_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_tick           (lcsr_pkg::lcsr_tick_t'(q_out[TICK_W-1:0])),
    .q_sum            (q_out[Q_W-1:TICK_W]),
    .q_pop            (q_pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_sck          (out_sck),
    .out_raw_valid    (out_raw_valid),
    .out_raw_sample   (out_raw_sample),
    .out_average_valid(out_average_valid),
    .out_average      (out_average),
    .out_net_value    (out_net_value)
  );

  // an averaged reading always comes with its closing sample
  a_avg_with_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_average_valid |-> out_raw_valid)
    else $error("average without raw sample");

  // a sample completes on the tick that drives the clock low
  a_raw_clock_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_raw_valid |-> !out_sck)
    else $error("sample reported with clock high");

  // average fields are zero unless an average is reported
  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_average_valid |-> (out_average == '0) && (out_net_value == '0))
    else $error("average fields set without average");

  // no stall on the input while the queue is empty
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !q_empty)
    else $error("input stalled with empty queue");

endmodule

FILE: tb/lcsr_checker.sv
// lcsr_checker: result checker for load_cell_adc_serial_reader
// watches the config, tick and result ports, predicts every result and compares it
// depends on lcsr_pkg

module lcsr_checker
  import lcsr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_dout,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_sck,
  input  logic                    out_raw_valid,
  input  logic [RAW_W-1:0]        out_raw_sample,
  input  logic                    out_average_valid,
  input  logic [RAW_W-1:0]        out_average,
  input  logic [NET_W-1:0]        out_net_value,
  output int                      readouts_pending,
  output int                      readout_errors
);

  localparam int FRAME_BITS  = 24;
  localparam int MAX_AVG     = 256;

  // everything the block reports for one tick
  typedef struct packed {
    logic             sck;
    logic             raw_valid;
    logic [RAW_W-1:0] raw_sample;
    logic             average_valid;
    logic [RAW_W-1:0] average;
    logic [NET_W-1:0] net_value;
  } readout_t;

  // register copies
  logic [GAIN_W-1:0]       gain_reg;
  logic [COUNT_W-1:0]      count_reg;
  logic signed [RAW_W-1:0] tare_reg;
  logic                    pd_reg;

  // serial interface and averaging state
  bit               in_frame;
  bit               sck_high;
  int unsigned      pulse_no;
  logic [RAW_W-1:0] shreg;
  longint           acc_sum;
  int unsigned      acc_n;

  readout_t awaited_q[$];
  int       result_no;
  int       error_cnt;

  assign readout_errors = error_cnt;

  task automatic reset_model();
    gain_reg  = GAIN_W'(1);
    count_reg = COUNT_W'(1);
    tare_reg  = '0;
    pd_reg    = 1'b0;
    in_frame  = 0;
    sck_high  = 0;
    pulse_no  = 0;
    shreg     = '0;
    acc_sum   = 0;
    acc_n     = 0;
  endtask

  // one tick of the converter interface: clock level, finished sample, finished average
  task automatic advance_readout(input logic pin, output readout_t o);
    int unsigned extra;
    longint      divisor;
    longint      avg;
    longint      net;
    o = '0;
    if (pd_reg) begin
      // powered down: clock held high, frame dropped, sum kept
      in_frame = 0;
      pulse_no = 0;
      shreg    = '0;
      sck_high = 1;
      o.sck    = 1'b1;
    end else if (!in_frame) begin
      // idle: a low pin starts a frame only once the clock is already low
      if (!sck_high && pin == 1'b0) begin
        in_frame = 1;
        pulse_no = 0;
        shreg    = '0;
        sck_high = 1;
        o.sck    = 1'b1;
      end else begin
        sck_high = 0;
        o.sck    = 1'b0;
      end
    end else if (!sck_high) begin
      sck_high = 1;
      o.sck    = 1'b1;
    end else begin
      // high tick: sample the pin, then drop the clock
      extra = (gain_reg == 0) ? 1 : gain_reg;
      if (pulse_no < FRAME_BITS) shreg = {shreg[RAW_W-2:0], pin};
      pulse_no++;
      sck_high = 0;
      o.sck    = 1'b0;
      if (pulse_no >= FRAME_BITS + extra) begin
        in_frame     = 0;
        pulse_no     = 0;
        o.raw_valid  = 1'b1;
        o.raw_sample = shreg;
        shreg        = '0;
        divisor = (count_reg == 0) ? 1 : ((count_reg > MAX_AVG) ? MAX_AVG : count_reg);
        acc_sum += longint'($signed(o.raw_sample));
        acc_n++;
        // the reading closes as soon as the tally reaches the current count
        if (acc_n >= divisor) begin
          avg             = acc_sum / divisor;
          net             = avg - longint'(tare_reg);
          o.average_valid = 1'b1;
          o.average       = avg[RAW_W-1:0];
          o.net_value     = net[NET_W-1:0];
          acc_sum         = 0;
          acc_n           = 0;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("result %0d: %s", result_no, msg);
    error_cnt++;
  endtask

  task automatic compare_field(input string name, input logic [NET_W-1:0] got_v,
                               input logic [NET_W-1:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s got %h expected %h", name, got_v, want_v));
  endtask

  // track config writes, predict accepted ticks, check accepted results
  always @(posedge clk) begin : monitor
    readout_t want;
    readout_t got;
    if (!rst_n) begin
      reset_model();
      awaited_q.delete();
      result_no = 0;
      error_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_PULSES:  gain_reg  = cfg_wdata[GAIN_W-1:0];
          REG_SAMPLE_COUNT: count_reg = cfg_wdata[COUNT_W-1:0];
          REG_TARE_OFFSET:  tare_reg  = cfg_wdata[RAW_W-1:0];
          REG_POWER_DOWN:   pd_reg    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_readout(in_dout, want);
        awaited_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got.sck           = out_sck;
        got.raw_valid     = out_raw_valid;
        got.raw_sample    = out_raw_sample;
        got.average_valid = out_average_valid;
        got.average       = out_average;
        got.net_value     = out_net_value;
        if (awaited_q.size() == 0) begin
          report_mismatch("result with no tick outstanding");
        end else begin
          want = awaited_q.pop_front();
          compare_field("sck", NET_W'(got.sck), NET_W'(want.sck));
          compare_field("raw_valid", NET_W'(got.raw_valid), NET_W'(want.raw_valid));
          compare_field("raw_sample", NET_W'(got.raw_sample), NET_W'(want.raw_sample));
          compare_field("average_valid", NET_W'(got.average_valid),
                        NET_W'(want.average_valid));
          compare_field("average", NET_W'(got.average), NET_W'(want.average));
          compare_field("net_value", got.net_value, want.net_value);
        end
        result_no++;
      end
    end
    readouts_pending <= awaited_q.size();
  end

endmodule

FILE: tb/tb.sv
// tb: top of the load_cell_adc_serial_reader testbench
// drives converter ticks and register writes, stalls the result side, gives the verdict
// depends on lcsr_pkg, load_cell_adc_serial_reader and lcsr_checker

module tb;
  import lcsr_pkg::*;

  localparam int          FRAME_BITS   = 24;
  localparam int          SETTLE_TICKS = 2 * (FRAME_BITS + 3) + 2;
  localparam int          RANDOM_TICKS = 700;
  localparam int          SAT_FRAMES   = 4;
  localparam int          LONG_HOLD    = 200;
  localparam int          TAIL_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_dout;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_sck;
  logic                  out_raw_valid;
  logic signed [RAW_W-1:0] out_raw_sample;
  logic                  out_average_valid;
  logic signed [RAW_W-1:0] out_average;
  logic signed [NET_W-1:0] out_net_value;

  int          outstanding;
  int          mismatches;
  bit          idle_on    = 1'b1;
  bit          hold_go    = 1'b0;
  int unsigned sent_ticks = 0;
  int unsigned cycle_cnt  = 0;
  logic [GAIN_W-1:0] gain_now = GAIN_W'(1);

  load_cell_adc_serial_reader u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_dout           (in_dout),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sck           (out_sck),
    .out_raw_valid     (out_raw_valid),
    .out_raw_sample    (out_raw_sample),
    .out_average_valid (out_average_valid),
    .out_average       (out_average),
    .out_net_value     (out_net_value)
  );

  lcsr_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_dout           (in_dout),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sck           (out_sck),
    .out_raw_valid     (out_raw_valid),
    .out_raw_sample    (out_raw_sample),
    .out_average_valid (out_average_valid),
    .out_average       (out_average),
    .out_net_value     (out_net_value),
    .readouts_pending  (outstanding),
    .readout_errors    (mismatches)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("load_cell_adc_serial_reader: mismatch");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold to back the block up
  initial begin : result_side
    int burst;
    bit hold_done;
    hold_done = 0;
    out_stall <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // one tick item, with an occasional gap before it
  task automatic send_tick(input logic level);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_dout  <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_ticks++;
  endtask

  // a whole frame from an idle, clock-low start: start tick, then sample and raise ticks
  task automatic send_frame(input logic [RAW_W-1:0] bits);
    int pulses;
    int i;
    pulses = (gain_now == 0) ? 1 : int'(gain_now);
    send_tick(1'b0);
    for (i = 0; i < FRAME_BITS + pulses; i++) begin
      if (i != 0) send_tick(1'($urandom_range(0, 1)));
      send_tick((i < FRAME_BITS) ? bits[FRAME_BITS-1-i] : 1'($urandom_range(0, 1)));
    end
  endtask

  // pin held high long enough to finish any frame and leave the clock low
  task automatic settle();
    repeat (SETTLE_TICKS) send_tick(1'b1);
  endtask

  // wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // write all four registers, with junk above the narrow fields
  task automatic configure(input logic [GAIN_W-1:0] g, input logic [COUNT_W-1:0] n,
                           input logic [RAW_W-1:0] t, input logic pd);
    gain_now = g;
    cfg_we    <= 1'b1;
    cfg_index <= REG_GAIN_PULSES;
    cfg_wdata <= CFG_DATA_W'(($urandom & ~32'h3) | 32'(g));
    @(posedge clk);
    cfg_index <= REG_SAMPLE_COUNT;
    cfg_wdata <= CFG_DATA_W'(($urandom & ~32'h1FF) | 32'(n));
    @(posedge clk);
    cfg_index <= REG_TARE_OFFSET;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_index <= REG_POWER_DOWN;
    cfg_wdata <= CFG_DATA_W'(($urandom & ~32'h1) | 32'(pd));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [RAW_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'hFFFFFF;
      3: return 24'h000000;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COUNT_W'($urandom_range(5, 16));
      2: return COUNT_W'($urandom);
      default: return COUNT_W'($urandom_range(1, 4));
    endcase
  endfunction

  // stimulus and verdict
  initial begin : stimulus
    int unsigned random_start;
    int unsigned phase_no;
    logic [GAIN_W-1:0]  g;
    logic [COUNT_W-1:0] n;
    logic [RAW_W-1:0]   t;
    logic               pd;
    bit                 resync;
    bit                 hold_sent;

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_GAIN_PULSES;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_dout   <= 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // zero gain and zero count both act as one; tare at the positive extreme
    configure(2'd0, 9'd0, 24'h7FFFFF, 1'b0);
    send_frame(24'h7FFFFF);
    send_frame(24'h800000);
    drain();
    // most gain pulses, tare at the negative extreme
    configure(2'd3, 9'd1, 24'h800000, 1'b0);
    send_frame(24'hFFFFFF);
    send_frame(24'h7FFFFF);
    send_frame(24'h000000);
    drain();
    // largest count, then lowered with three samples already summed
    configure(2'd2, 9'd256, 24'h000001, 1'b0);
    repeat (3) send_frame(pick_level());
    drain();
    configure(2'd2, 9'd2, 24'h000001, 1'b0);
    send_frame(24'h800000);
    // one sample into the next reading, then a frame cut by power down
    send_frame(pick_level());
    send_tick(1'b0);
    repeat (19) send_tick(1'($urandom_range(0, 1)));
    drain();
    configure(2'd2, 9'd2, 24'h000001, 1'b1);
    repeat (6) send_tick(1'($urandom_range(0, 1)));
    drain();
    configure(2'd2, 9'd2, 24'h000001, 1'b0);
    // clock still high after power down: a low pin must not start a frame here
    send_tick(1'b0);
    send_frame(pick_level());
    drain();

    // random phases: mostly clean frames, some noise and cut frames
    random_start = sent_ticks;
    phase_no     = 0;
    resync       = 0;
    hold_sent    = 0;
    while (sent_ticks - random_start < RANDOM_TICKS) begin
      phase_no++;
      g  = GAIN_W'($urandom);
      n  = pick_count();
      t  = pick_level();
      pd = ($urandom_range(0, 11) == 0);
      configure(g, n, t, pd);
      if (pd) begin
        repeat ($urandom_range(2, 20)) send_tick(1'($urandom_range(0, 1)));
        resync = 1;
      end else begin
        if (resync) send_tick(1'($urandom_range(0, 1)));
        resync = 0;
        if (!hold_sent && phase_no >= 1) begin
          hold_go <= 1'b1;
          hold_sent = 1;
        end
        repeat ($urandom_range(2, 5)) begin
          case ($urandom_range(0, 9))
            0: begin
              repeat ($urandom_range(4, 60)) send_tick(1'($urandom_range(0, 1)));
              settle();
            end
            1: begin
              send_tick(1'b0);
              repeat ($urandom_range(1, 40)) send_tick(1'($urandom_range(0, 1)));
              settle();
            end
            default: begin
              repeat ($urandom_range(0, 4)) send_tick(1'b1);
              send_frame(pick_level());
            end
          endcase
        end
      end
      drain();
    end

    // no idling from here: an oversized count saturates and keeps summing,
    // then a lowered count closes the reading over every sample so far
    idle_on <= 1'b0;
    configure(2'd1, 9'h1FF, pick_level(), 1'b0);
    if (resync) send_tick(1'b1);
    repeat (SAT_FRAMES) send_frame(pick_level());
    drain();
    configure(2'd1, 9'd2, pick_level(), 1'b0);
    send_frame(pick_level());
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("load_cell_adc_serial_reader: match");
    else
      $display("load_cell_adc_serial_reader: mismatch");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lcsr_pkg.sv
hw/rtl/lcsr_fifo.sv
hw/rtl/lcsr_front.sv
hw/rtl/lcsr_back.sv
hw/rtl/load_cell_adc_serial_reader.sv
tb/lcsr_checker.sv
tb/tb.sv
